FILE: rtl/msosc_pkg.sv
// Shared constants for the multiphase sine oscillator.
// Voice count, sine table size, phase format and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps

package msosc_pkg;

  localparam int VOICE_COUNT     = 16;
  localparam int SINE_TABLE_BITS = 10;

  // Address width of the per-voice phase store.
  localparam int VADDR_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  localparam int PHASE_W = 32;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCUMULATE_MODE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INCREMENT   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOICE_OFFSET_STEP = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_DEPTH      = 8'd3;

  localparam logic [31:0] PHASE_INCREMENT_RST   = 32'd89478;
  localparam logic [15:0] VOICE_OFFSET_STEP_RST = 16'd4096;

  // round(2^32 / (2*pi)), radians in Q.26 to cycles in Q.32 after a shift by 26.
  localparam logic signed [30:0] INV_TWO_PI_Q32 = 31'sd683565276;

endpackage

FILE: rtl/msosc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the per-voice phase store. No dependencies.
`timescale 1ns / 1ps

module msosc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/msosc_sine.sv
// Quarter-wave sine lookup: maps a 32-bit phase to a signed full-scale sample.
// Depends on msosc_pkg for the table size.
`timescale 1ns / 1ps

module msosc_sine (
  input  logic [msosc_pkg::PHASE_W-1:0] theta_i,
  output logic signed [15:0]            sample_o
);
  import msosc_pkg::*;

  localparam int TB       = SINE_TABLE_BITS;
  localparam int QTR_SIZE = 1 << (TB - 2);

  typedef logic [14:0] qtr_tbl_t [QTR_SIZE + 1];

  // Restoring long division, evaluated only while the table is built.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Taylor series through x^15 on the quarter wave, Q30, rounded to 32767 full scale.
  function automatic qtr_tbl_t build_qtr();
    qtr_tbl_t    t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] sc;
    for (int k = 0; k <= QTR_SIZE; k++) begin
      x    = (64'(k) * 64'd6746518852) >> TB;
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      neg  = 64'd0;
      for (int n = 1; n <= 7; n++) begin
        term = udiv64((term * x2) >> 30, 64'(2 * n) * 64'(2 * n + 1));
        if ((n & 1) == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      s  = (pos > neg) ? (pos - neg) : 64'd0;
      sc = (s * 64'd32767 + 64'd536870912) >> 30;
      if (sc > 64'd32767) begin
        sc = 64'd32767;
      end
      t[k] = 15'(sc);
    end
    return t;
  endfunction

  localparam qtr_tbl_t QTR_TBL = build_qtr();

  logic [TB-1:0] idx;
  logic [1:0]    quad;
  logic [TB-3:0] r;
  logic [TB-3:0] mir;
  logic [14:0]   mag;

  assign idx  = theta_i[PHASE_W-1 -: TB];
  assign quad = idx[TB-1:TB-2];
  assign r    = idx[TB-3:0];
  // Mirror index wraps; the peak entry stands outside the addressed range.
  assign mir  = (TB-2)'(0) - r;

  always_comb begin
    if (!quad[0]) begin
      mag = QTR_TBL[r];
    end else if (r == '0) begin
      mag = QTR_TBL[QTR_SIZE];
    end else begin
      mag = QTR_TBL[mir];
    end
    sample_o = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

FILE: rtl/multiphase_sine_oscillator_top.sv
// Top level of the multiphase sine oscillator: sequencer, voice phase store,
// offset arithmetic and output register. Depends on msosc_pkg, msosc_ram, msosc_sine.
`timescale 1ns / 1ps

// Each request names a voice and produces one sample: the accept cycle issues
// the read of the voice's phase accumulator, then the sequencer steps through the
// accumulator update and write-back, the radian-to-cycle offset multiply, and the
// phase sum with sine lookup into the output register, which waits until that
// register is free. A new request is taken once the sequencer is back at idle,
// even while the previous sample waits in the output register.
// Accumulators read as zero after reset through per-voice valid bits.
// Configuration writes are always accepted and should be issued only while idle.
module multiphase_sine_oscillator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [msosc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [msosc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [3:0]                          voice_i,
  input  logic signed [20:0]                  external_phase_i,
  input  logic signed [15:0]                  offset_control_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [3:0]                          voice_out_o,
  output logic signed [15:0]                  sine_sample_o
);
  import msosc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_SUM  = 2'd3;

  // Configuration registers.
  logic               acc_mode_q;
  logic [31:0]        phase_inc_q;
  logic [15:0]        voff_step_q;
  logic signed [15:0] offset_depth_q;

  logic [1:0] state_q, state_d;

  logic [3:0]               voice_q;
  logic [15:0]              ext_frac_q;
  logic signed [15:0]       ctrl_q;
  logic                     in_range_q;
  logic signed [31:0]       prod_q;
  logic [PHASE_W-1:0]       base_q;
  logic [PHASE_W-1:0]       cp_q;
  logic [VOICE_COUNT-1:0]   vld_q;

  logic                     out_valid_q;
  logic [3:0]               voice_out_q;
  logic signed [15:0]       sample_q;

  logic                     in_fire;
  logic                     sum_go;
  logic [VADDR_W-1:0]       raddr;
  logic [VADDR_W-1:0]       waddr;
  logic [PHASE_W-1:0]       rdata;
  logic [PHASE_W-1:0]       acc_old;
  logic [PHASE_W-1:0]       acc_new;
  logic                     ram_we;
  logic signed [31:0]       prod_d;
  logic signed [62:0]       cp_full;
  logic [19:0]              voff_full;
  logic [PHASE_W-1:0]       theta;
  logic signed [15:0]       lut_sample;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign sum_go      = (state_q == S_SUM) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_mode_q     <= 1'b0;
      phase_inc_q    <= PHASE_INCREMENT_RST;
      voff_step_q    <= VOICE_OFFSET_STEP_RST;
      offset_depth_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ACCUMULATE_MODE:   acc_mode_q     <= cfg_data_i[0];
        CFG_PHASE_INCREMENT:   phase_inc_q    <= cfg_data_i[31:0];
        CFG_VOICE_OFFSET_STEP: voff_step_q    <= cfg_data_i[15:0];
        CFG_OFFSET_DEPTH:      offset_depth_q <= $signed(cfg_data_i[15:0]);
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_ACC;
      S_ACC:  state_d = S_MUL;
      S_MUL:  state_d = S_SUM;
      S_SUM:  if (sum_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Phase store: read on accept, update and write back in the following cycle.
  assign raddr   = VADDR_W'(voice_i);
  assign waddr   = VADDR_W'(voice_q);
  assign acc_old = vld_q[waddr] ? rdata : '0;
  assign acc_new = acc_old + phase_inc_q;
  assign ram_we  = (state_q == S_ACC) && acc_mode_q && in_range_q;

  msosc_ram #(
    .WIDTH (PHASE_W),
    .DEPTH (VOICE_COUNT)
  ) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (acc_new),
    .re_i    (in_fire),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ram_we) begin
      vld_q[waddr] <= 1'b1;
    end
  end

  // Datapath.
  assign prod_d    = ctrl_q * offset_depth_q;
  assign cp_full   = prod_q * INV_TWO_PI_Q32;
  assign voff_full = voice_q * voff_step_q;
  assign theta     = base_q + cp_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      voice_q    <= voice_i;
      ext_frac_q <= external_phase_i[15:0];
      ctrl_q     <= offset_control_i;
      in_range_q <= (int'(voice_i) < VOICE_COUNT);
    end
    if (state_q == S_ACC) begin
      prod_q <= prod_d;
      base_q <= acc_mode_q ? acc_new : {ext_frac_q, 16'd0};
    end
    if (state_q == S_MUL) begin
      cp_q   <= cp_full[57:26];
      base_q <= base_q + {voff_full[15:0], 16'd0};
    end
  end

  msosc_sine u_sine (
    .theta_i  (theta),
    .sample_o (lut_sample)
  );

  // Output register: hold the sample until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sum_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_go) begin
      voice_out_q <= voice_q;
      sample_q    <= in_range_q ? lut_sample : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign voice_out_o   = voice_out_q;
  assign sine_sample_o = sample_q;

`ifndef SYNTH
  a_accept_starts_acc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_ACC)
    else $error("accepted request did not enter accumulate step");

  a_write_only_in_acc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> $past(in_fire) && $past(state_q) == S_IDLE)
    else $error("phase write not one cycle after its read");

  a_valid_bits_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q & $past(vld_q)) == $past(vld_q))
    else $error("phase valid bit dropped");

  a_out_from_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_SUM)
    else $error("result shown without finishing the sum step");
`endif

endmodule

FILE: tb/sv/testbench.sv
// Self-checking bench for multiphase_sine_oscillator_top: a directed table, then
// random phases with fresh register settings, predicted in-bench per voice but for typed rows.
// Depends on msosc_pkg and the RTL of the oscillator.
`timescale 1ns / 1ps

module testbench;
  import msosc_pkg::*;

  localparam int QTR_SIZE = (1 << SINE_TABLE_BITS) >> 2;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint unsigned RAD_TO_CYCLES = 64'd683565276;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_REQUESTS = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;

  typedef enum logic [0:0] {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e kind;
    logic [7:0] index;
    logic [31:0] data;
    logic [3:0] voice;
    logic [20:0] ext;
    logic [15:0] ctrl;
    bit typed;
    logic [15:0] sample;
  } stim_row_t;

  typedef struct packed {
    logic [3:0] voice;
    logic [15:0] sample;
  } sample_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [3:0] voice_i;
  logic signed [20:0] external_phase_i;
  logic signed [15:0] offset_control_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [3:0] voice_out_o;
  logic signed [15:0] sine_sample_o;

  // Predictor state.
  int quarter_wave [0:QTR_SIZE];
  logic [31:0] phase_acc [VOICE_COUNT];
  logic acc_mode;
  logic [31:0] phase_incr;
  logic [15:0] voice_step;
  logic signed [15:0] offset_depth;

  sample_t pending_samples[$];
  stim_row_t directed[$];
  int fail_count = 0;
  int samples_seen = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  bit hold_off_pending = 1'b0;

  multiphase_sine_oscillator_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .voice_i          (voice_i),
    .external_phase_i (external_phase_i),
    .offset_control_i (offset_control_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .voice_out_o      (voice_out_o),
    .sine_sample_o    (sine_sample_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [15:0] predict_sample(logic [3:0] voice, logic [20:0] ext,
                                                  logic signed [15:0] ctrl);
    logic [31:0] base;
    logic [31:0] theta;
    longint signed prod;
    longint unsigned turn;
    int idx;
    int quad;
    int r;
    int mag;
    if (int'(voice) >= VOICE_COUNT) return 16'd0;
    if (acc_mode) begin
      phase_acc[voice] = phase_acc[voice] + phase_incr;
      base = phase_acc[voice];
    end else begin
      // integer cycles drop out: only the fraction lands in the phase word
      base = {ext[15:0], 16'h0000};
    end
    prod = longint'(ctrl) * longint'(offset_depth);
    turn = ($unsigned(prod) * RAD_TO_CYCLES) >> 26;
    theta = base + ((32'(voice) * 32'(voice_step)) << 16) + turn[31:0];
    idx = int'(theta >> (32 - SINE_TABLE_BITS));
    quad = (idx >> (SINE_TABLE_BITS - 2)) & 3;
    r = idx & (QTR_SIZE - 1);
    mag = (quad == 0 || quad == 2) ? quarter_wave[r] : quarter_wave[QTR_SIZE - r];
    return (quad >= 2) ? 16'(-mag) : 16'(mag);
  endfunction

  // Zero, all ones, sign bit alone, all but sign bit, or anything.
  function automatic logic [31:0] edgy_value(int width, int spread);
    logic [31:0] ones;
    ones = (width >= 32) ? '1 : ((32'd1 << width) - 32'd1);
    case ($urandom_range(spread))
      0: return '0;
      1: return ones;
      2: return 32'd1 << (width - 1);
      3: return ones >> 1;
      default: return $urandom() & ones;
    endcase
  endfunction

  // Stray bits above the register width must be ignored.
  function automatic logic [31:0] reg_value(int width);
    logic [31:0] v;
    v = edgy_value(width, 5);
    if (width < 32) v = v | ($urandom() << width);
    return v;
  endfunction

  function automatic stim_row_t req_row(logic [3:0] voice, logic [20:0] ext, logic [15:0] ctrl,
                                        bit typed = 1'b0, int sample = 0);
    stim_row_t row;
    row = '{ROW_REQ, '0, '0, voice, ext, ctrl, typed, 16'(sample)};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [7:0] index, logic [31:0] data);
    stim_row_t row;
    row = '{ROW_CFG, index, data, '0, '0, '0, 1'b0, '0};
    return row;
  endfunction

  task automatic send_request(input logic [3:0] voice, input logic [20:0] ext,
                              input logic [15:0] ctrl, input bit typed,
                              input logic [15:0] typed_sample);
    sample_t want;
    while (!calm && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    voice_i <= voice;
    external_phase_i <= ext;
    offset_control_i <= ctrl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    want.voice = voice;
    want.sample = predict_sample(voice, ext, ctrl);
    if (typed) want.sample = typed_sample;
    pending_samples.push_back(want);
  endtask

  // Write only once the pipeline has drained.
  task automatic write_reg(input logic [7:0] index, input logic [31:0] data);
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (index)
      CFG_ACCUMULATE_MODE:   acc_mode = data[0];
      CFG_PHASE_INCREMENT:   phase_incr = data;
      CFG_VOICE_OFFSET_STEP: voice_step = data[15:0];
      CFG_OFFSET_DEPTH:      offset_depth = data[15:0];
      default: ;
    endcase
  endtask

  // Output side: random back-pressure, one long hold-off on request.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_pending) begin
        hold_off_pending <= 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= calm || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk_i) begin
    sample_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      samples_seen++;
      if (pending_samples.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected sample %0d: voice %0d value %0d", samples_seen, voice_out_o,
                   sine_sample_o);
      end else begin
        want = pending_samples.pop_front();
        if (voice_out_o !== want.voice || sine_sample_o !== want.sample) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch at sample %0d: voice exp %0d got %0d, value exp %0d got %0d",
                     samples_seen, want.voice, voice_out_o, $signed(want.sample),
                     sine_sample_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    longint unsigned x, x2, term, pos, neg, s, scaled;
    int k;
    int n;

    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    voice_i <= '0;
    external_phase_i <= '0;
    offset_control_i <= '0;

    // Quarter-wave table: truncated Taylor series in Q30, rounded to full scale.
    for (k = 0; k <= QTR_SIZE; k++) begin
      x = (64'(k) * TWO_PI_Q30) >> SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      term = x;
      pos = x;
      neg = 0;
      for (n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) neg += term;
        else pos += term;
      end
      s = (pos > neg) ? pos - neg : 64'd0;
      scaled = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      quarter_wave[k] = (scaled > 64'd32767) ? 32767 : int'(scaled);
    end

    acc_mode = 1'b0;
    phase_incr = PHASE_INCREMENT_RST;
    voice_step = VOICE_OFFSET_STEP_RST;
    offset_depth = '0;
    foreach (phase_acc[i]) phase_acc[i] = '0;

    // Reset values first: external phase, zero depth, step of 1/16 turn.
    directed.push_back(req_row(4'd0, 21'h000000, 16'h0000, 1'b1, 0));
    directed.push_back(req_row(4'd0, 21'h004000, 16'h7FFF, 1'b1, 32767));
    directed.push_back(req_row(4'd0, 21'h008000, 16'h8000, 1'b1, 0));
    directed.push_back(req_row(4'd0, 21'h00C000, 16'h0000, 1'b1, -32767));
    directed.push_back(req_row(4'd15, 21'h0FFFFF, 16'h0001));
    directed.push_back(req_row(4'd8, 21'h100000, 16'h7FFF, 1'b1, 0));
    directed.push_back(req_row(4'd1, 21'h1FFFFF, 16'hFFFF));
    // Offset control at both depth extremes.
    directed.push_back(cfg_row(CFG_OFFSET_DEPTH, 32'h0000_7FFF));
    directed.push_back(cfg_row(CFG_VOICE_OFFSET_STEP, 32'h0000_0000));
    directed.push_back(req_row(4'd3, 21'h000000, 16'h7FFF));
    directed.push_back(req_row(4'd3, 21'h000000, 16'h8000));
    directed.push_back(cfg_row(CFG_OFFSET_DEPTH, 32'hFFFF_8000));
    directed.push_back(req_row(4'd5, 21'h001234, 16'h8000));
    directed.push_back(req_row(4'd5, 21'h1ABCD, 16'h7FFF));
    directed.push_back(cfg_row(CFG_VOICE_OFFSET_STEP, 32'hABCD_FFFF));
    directed.push_back(cfg_row(8'(CFG_OFFSET_DEPTH + 1), 32'hFFFF_FFFF));
    directed.push_back(cfg_row(8'hFF, 32'h0000_0000));
    directed.push_back(req_row(4'd15, 21'h00FFFF, 16'h0001));
    // Accumulators: maximal increment wraps every step, zero holds, a quarter turn steps round.
    directed.push_back(cfg_row(CFG_ACCUMULATE_MODE, 32'hFFFF_FFFF));
    directed.push_back(cfg_row(CFG_PHASE_INCREMENT, 32'hFFFF_FFFF));
    directed.push_back(req_row(4'd0, 21'h000000, 16'h0000));
    directed.push_back(req_row(4'd0, 21'h0FFFFF, 16'h1234));
    directed.push_back(req_row(4'd15, 21'h100000, 16'h8000));
    directed.push_back(cfg_row(CFG_PHASE_INCREMENT, 32'h0000_0000));
    directed.push_back(req_row(4'd2, 21'h000000, 16'h0000));
    directed.push_back(cfg_row(CFG_PHASE_INCREMENT, 32'h4000_0000));
    repeat (4) directed.push_back(req_row(4'd7, 21'h000000, 16'h0000));
    // External mode must leave the accumulator alone.
    directed.push_back(cfg_row(CFG_ACCUMULATE_MODE, 32'h0000_0000));
    directed.push_back(req_row(4'd7, 21'h00ABCD, 16'h0000));
    directed.push_back(cfg_row(CFG_ACCUMULATE_MODE, 32'h0000_0001));
    directed.push_back(req_row(4'd7, 21'h000000, 16'h0000));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG)
        write_reg(directed[i].index, directed[i].data);
      else
        send_request(directed[i].voice, directed[i].ext, directed[i].ctrl, directed[i].typed,
                     directed[i].sample);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_ACCUMULATE_MODE, reg_value(1));
      write_reg(CFG_PHASE_INCREMENT, reg_value(32));
      write_reg(CFG_VOICE_OFFSET_STEP, reg_value(16));
      write_reg(CFG_OFFSET_DEPTH, reg_value(16));
      if ($urandom_range(1) == 1)
        write_reg(8'($urandom_range(255, int'(CFG_OFFSET_DEPTH) + 1)), $urandom());
      if (p == 2) hold_off_pending <= 1'b1;
      calm <= (p == 4);
      for (int j = 0; j < PHASE_REQUESTS; j++)
        send_request(4'($urandom_range(15)), 21'(edgy_value(21, 31)),
                     16'(edgy_value(16, 31)), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
